@@ rtl/gsdp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the group scaled int8 dot product block
// no dependencies
package gsdp_pkg;

	localparam int GROUP_SIZE = 64;
	localparam int LANES      = 4;
	localparam int MAX_LANES  = 4;

	// group dot must hold GROUP_SIZE * 128 * 128 with a sign bit
	localparam int DOT_W    = $clog2(GROUP_SIZE * 16384 + 1) + 1;
	localparam int PROD_W   = 16;
	localparam int LSUM_W   = PROD_W + 2;
	localparam int ACT_W    = 32;
	localparam int HALF_W   = 16;
	localparam int MANT_W   = 11;
	localparam int SUM_W    = 64;
	localparam int P1_W     = DOT_W + ACT_W;
	localparam int MAG_W    = P1_W + MANT_W;
	localparam int LSH_MAX  = 13;
	localparam int TERM_W   = MAG_W + 1 + LSH_MAX + 1;

	// half float fields
	localparam logic [4:0] EXP_SPECIAL = 5'd31;
	localparam logic [4:0] EXP_ZERO    = 5'd0;
	localparam logic [4:0] EXP_SUB     = 5'd1;
	localparam logic [4:0] RSH_BASE    = 5'd30;

	// close queue
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// one closed group handed from front to back
	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [ACT_W-1:0]        act_scale;
		logic [HALF_W-1:0]       half;
		logic                    oend;
	} cls_t;

endpackage

@@ rtl/gsdp_front.sv @@
`timescale 1ns / 1ps
// front end: lane products, group dot accumulation, group close hand-off
// depends on gsdp_pkg
module gsdp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic signed [7:0]        act_a,
	input  logic signed [7:0]        act_b,
	input  logic signed [7:0]        act_c,
	input  logic signed [7:0]        act_d,
	input  logic signed [7:0]        wgt_a,
	input  logic signed [7:0]        wgt_b,
	input  logic signed [7:0]        wgt_c,
	input  logic signed [7:0]        wgt_d,
	input  logic [31:0]              act_scale,
	input  logic [15:0]              wgt_scale_half,
	input  logic                     group_end,
	input  logic                     output_end,
	output logic                     cls_push,
	output gsdp_pkg::cls_t           cls_word
);
	import gsdp_pkg::*;

	logic signed [7:0]        act_v [MAX_LANES];
	logic signed [7:0]        wgt_v [MAX_LANES];
	logic signed [LSUM_W-1:0] lane_sum;
	logic signed [DOT_W-1:0]  dot_next;
	logic signed [DOT_W-1:0]  group_dot_q;

	assign act_v[0] = act_a;
	assign act_v[1] = act_b;
	assign act_v[2] = act_c;
	assign act_v[3] = act_d;
	assign wgt_v[0] = wgt_a;
	assign wgt_v[1] = wgt_b;
	assign wgt_v[2] = wgt_c;
	assign wgt_v[3] = wgt_d;

	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			lane_sum = lane_sum + LSUM_W'(act_v[i] * wgt_v[i]);
		end
	end

	// wraps modulo 2^DOT_W
	assign dot_next = group_dot_q + DOT_W'(lane_sum);

	assign cls_push           = accept & (group_end | output_end);
	assign cls_word.dot       = dot_next;
	assign cls_word.act_scale = act_scale;
	assign cls_word.half      = wgt_scale_half;
	assign cls_word.oend      = output_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_dot_q <= '0;
		end else if (accept) begin
			group_dot_q <= (group_end | output_end) ? '0 : dot_next;
		end
	end

endmodule

@@ rtl/gsdp_queue.sv @@
`timescale 1ns / 1ps
// short queue of closed groups between front and back
// depends on gsdp_pkg
module gsdp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  gsdp_pkg::cls_t wr_word,
	output logic           q_full,
	output logic           q_empty,
	input  logic           rd_en,
	output gsdp_pkg::cls_t rd_word
);
	import gsdp_pkg::*;

	cls_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en & ~q_full;
	assign do_rd   = rd_en & ~q_empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/gsdp_back.sv @@
`timescale 1ns / 1ps
// back end: scale decode, two multiplies, shift, saturating add, result register
// depends on gsdp_pkg
module gsdp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  gsdp_pkg::cls_t                q_word,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [gsdp_pkg::SUM_W-1:0] sum_fixed,
	output logic                          overflow,
	output logic                          bad_scale
);
	import gsdp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_ADD   = 2'd3;

	logic [1:0]               state_q;
	logic [P1_W-1:0]          prod1_q;
	logic [MAG_W-1:0]         mag_q;
	logic [MANT_W-1:0]        mant_q;
	logic [4:0]               rsh_q;
	logic                     neg_q;
	logic                     oend_q;
	logic                     bad_q;
	logic signed [TERM_W-1:0] term_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     ovf_seen_q;
	logic                     bad_seen_q;
	logic                     out_valid_q;
	logic signed [SUM_W-1:0]  out_sum_q;
	logic                     out_ovf_q;
	logic                     out_bad_q;

	logic [DOT_W-1:0]         dot_abs;
	logic [4:0]               expo;
	logic [4:0]               exp_eff;
	logic signed [MAG_W:0]    sval;
	logic signed [TERM_W-1:0] sval_ext;
	logic signed [TERM_W-1:0] total;
	logic                     fits;
	logic signed [SUM_W-1:0]  new_sum;
	logic                     new_ovf;
	logic                     new_bad;
	logic                     add_go;

	assign q_pop = (state_q == ST_IDLE) & ~q_empty;

	// decode of the head word
	assign dot_abs = q_word.dot[DOT_W-1] ? DOT_W'(-q_word.dot) : DOT_W'(q_word.dot);
	assign expo    = q_word.half[14:10];
	// subnormal scales use exponent one without the hidden bit
	assign exp_eff = (expo == EXP_ZERO) ? EXP_SUB : expo;

	// signed term, pre-shifted left by the largest left shift, then floor right shift
	assign sval     = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
	assign sval_ext = {sval[MAG_W], sval, {LSH_MAX{1'b0}}};

	assign total = $signed({{(TERM_W-SUM_W){sum_q[SUM_W-1]}}, sum_q}) + term_q;
	assign fits  = (&total[TERM_W-1:SUM_W-1]) | ~(|total[TERM_W-1:SUM_W-1]);

	always_comb begin
		new_sum = sum_q;
		new_ovf = ovf_seen_q;
		new_bad = bad_seen_q | bad_q;
		if (!bad_q) begin
			if (fits) begin
				new_sum = total[SUM_W-1:0];
			end else begin
				new_sum = total[TERM_W-1] ? SUM_MIN : SUM_MAX;
				new_ovf = 1'b1;
			end
		end
	end

	assign add_go = (state_q == ST_ADD) & (~oend_q | ~out_valid_q | pop);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod1_q <= P1_W'(dot_abs) * P1_W'(q_word.act_scale);
			mant_q  <= (expo == EXP_ZERO) ? {1'b0, q_word.half[9:0]}
			                              : {1'b1, q_word.half[9:0]};
			rsh_q   <= RSH_BASE - exp_eff;
			neg_q   <= q_word.half[15] ^ q_word.dot[DOT_W-1];
			oend_q  <= q_word.oend;
			bad_q   <= (expo == EXP_SPECIAL);
		end
		if (state_q == ST_MUL) begin
			mag_q <= MAG_W'(prod1_q) * MAG_W'(mant_q);
		end
		if (state_q == ST_SHIFT) begin
			term_q <= sval_ext >>> rsh_q;
		end
		if (add_go && oend_q) begin
			out_sum_q <= new_sum;
			out_ovf_q <= new_ovf;
			out_bad_q <= new_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			ovf_seen_q  <= 1'b0;
			bad_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_ADD;
				ST_ADD: begin
					if (add_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (add_go) begin
				if (oend_q) begin
					sum_q      <= '0;
					ovf_seen_q <= 1'b0;
					bad_seen_q <= 1'b0;
				end else begin
					sum_q      <= new_sum;
					ovf_seen_q <= new_ovf;
					bad_seen_q <= new_bad;
				end
			end

			if (add_go && oend_q) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty     = ~out_valid_q;
	assign sum_fixed = out_sum_q;
	assign overflow  = out_ovf_q;
	assign bad_scale = out_bad_q;

endmodule

@@ rtl/group_scaled_int8_dot_product_top.sv @@
`timescale 1ns / 1ps
// top level of the group scaled int8 dot product block
// depends on gsdp_pkg, gsdp_front, gsdp_queue, gsdp_back
//
// Each input word carries four int8 activation/weight pairs; the front end adds
// their products into a 22-bit group dot and takes one word per clock while full
// is low. A word with group_end or output_end closes the group: the dot,
// activation scale (unsigned Q8.24), fp16 weight scale and output_end flag go
// into a four-deep close queue, and full is raised only when that queue has no
// room. The back end takes one closed group at a time through its steps (pop and
// dot x activation-scale multiply, x weight mantissa multiply, sign and exponent
// shift, saturating add into the Q32.32 running sum) and takes no new group until
// it is through with the last, so closing words that come faster than that fill
// the queue and hold the input. On output_end the sum and the sticky overflow and
// bad_scale flags land in the result register (empty goes low) when the closing
// group leaves the add step, and the sum and flags clear. An infinite or NaN
// weight scale adds nothing and sets bad_scale. The back end holds a group that
// carries output_end in its add step while an unread result still sits in the
// result register and is not popped.
module group_scaled_int8_dot_product_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [7:0]  act_a,
	input  logic signed [7:0]  act_b,
	input  logic signed [7:0]  act_c,
	input  logic signed [7:0]  act_d,
	input  logic signed [7:0]  wgt_a,
	input  logic signed [7:0]  wgt_b,
	input  logic signed [7:0]  wgt_c,
	input  logic signed [7:0]  wgt_d,
	input  logic [31:0]        act_scale,
	input  logic [15:0]        wgt_scale_half,
	input  logic               group_end,
	input  logic               output_end,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] sum_fixed,
	output logic               overflow,
	output logic               bad_scale
);
	import gsdp_pkg::*;

	logic accept;
	logic cls_push;
	cls_t cls_word;
	logic q_empty;
	logic q_pop;
	cls_t q_word;

	// word taken when the close queue has room
	assign accept = push & ~full;

	gsdp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.act_a          (act_a),
		.act_b          (act_b),
		.act_c          (act_c),
		.act_d          (act_d),
		.wgt_a          (wgt_a),
		.wgt_b          (wgt_b),
		.wgt_c          (wgt_c),
		.wgt_d          (wgt_d),
		.act_scale      (act_scale),
		.wgt_scale_half (wgt_scale_half),
		.group_end      (group_end),
		.output_end     (output_end),
		.cls_push       (cls_push),
		.cls_word       (cls_word)
	);

	gsdp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cls_push),
		.wr_word (cls_word),
		.q_full  (full),
		.q_empty (q_empty),
		.rd_en   (q_pop),
		.rd_word (q_word)
	);

	// sequential scale and accumulate, result register on the way out
	gsdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.sum_fixed (sum_fixed),
		.overflow  (overflow),
		.bad_scale (bad_scale)
	);

endmodule

@@ rtl/gsdp_checker.sv @@
`timescale 1ns / 1ps
// port level checks for the group scaled int8 dot product block
// depends on group_scaled_int8_dot_product_top (bound below)
module gsdp_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [63:0] sum_fixed,
	input logic        overflow,
	input logic        bad_scale
);

	// reset leaves no result waiting
	a_rst_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a waiting word that is not taken stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sum_fixed) && $stable(overflow)
		                     && $stable(bad_scale)))
		else $error("result word changed before it was taken");

	// the queue can only fill by taking a word
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without an input word");

	// no result can come out of reset at once
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> empty)
		else $error("result right after reset");

endmodule

bind group_scaled_int8_dot_product_top gsdp_port_props u_gsdp_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.sum_fixed (sum_fixed),
	.overflow  (overflow),
	.bad_scale (bad_scale)
);

@@ tb/gsdp_checker.sv @@
`timescale 1ns / 1ps
// checker for the group scaled int8 dot product block: predicts and compares output words
// depends on gsdp_pkg; watches the push and pop handshakes of the top level
module gsdp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [7:0]  act_a,
	input  logic signed [7:0]  act_b,
	input  logic signed [7:0]  act_c,
	input  logic signed [7:0]  act_d,
	input  logic signed [7:0]  wgt_a,
	input  logic signed [7:0]  wgt_b,
	input  logic signed [7:0]  wgt_c,
	input  logic signed [7:0]  wgt_d,
	input  logic [31:0]        act_scale,
	input  logic [15:0]        wgt_scale_half,
	input  logic               group_end,
	input  logic               output_end,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [63:0] sum_fixed,
	input  logic               overflow,
	input  logic               bad_scale,
	output int                 fail_count,
	output int                 results_owed
);
	import gsdp_pkg::*;

	// half bias plus frac bits, less the Q8.24 to Q32.32 alignment
	localparam int NORM_SHIFT_BIAS = 17;
	localparam int SUBNORM_SHIFT   = 1 - NORM_SHIFT_BIAS;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    ovf;
		logic                    bad;
	} out_word_t;

	logic signed [DOT_W-1:0] group_acc;
	logic signed [SUM_W-1:0] element_sum;
	logic                    sat_seen;
	logic                    nan_seen;
	out_word_t               owed_words[$];

	// exact dot x act scale x half scale, placed on the Q32.32 grid with floor
	function automatic logic signed [127:0] scaled_group_term(
		input logic signed [DOT_W-1:0] dot,
		input logic [ACT_W-1:0]        ascale,
		input logic [HALF_W-1:0]       half
	);
		logic [MANT_W-1:0]  mant;
		logic [DOT_W-1:0]   dot_mag;
		logic [63:0]        mag;
		logic signed [127:0] term;
		int                 sh;
		if (half[14:10] == EXP_ZERO) begin
			mant = {1'b0, half[9:0]};
			sh   = SUBNORM_SHIFT;
		end else begin
			mant = {1'b1, half[9:0]};
			sh   = int'(half[14:10]) - NORM_SHIFT_BIAS;
		end
		dot_mag = dot[DOT_W-1] ? -dot : dot;
		mag     = 64'(dot_mag) * 64'(ascale) * 64'(mant);
		term    = $signed({64'd0, mag});
		if (half[15] ^ dot[DOT_W-1])
			term = -term;
		if (sh > 0)
			term = term <<< sh;
		else
			term = term >>> (-sh);
		return term;
	endfunction

	task automatic absorb_word();
		logic signed [7:0]   av [MAX_LANES];
		logic signed [7:0]   wv [MAX_LANES];
		int                  lane_sum;
		logic signed [127:0] total;
		av = '{act_a, act_b, act_c, act_d};
		wv = '{wgt_a, wgt_b, wgt_c, wgt_d};
		lane_sum = 0;
		for (int l = 0; l < MAX_LANES; l++)
			if (l < LANES)
				lane_sum += int'(av[l]) * int'(wv[l]);
		group_acc = group_acc + DOT_W'(lane_sum);
		if (group_end || output_end) begin
			if (wgt_scale_half[14:10] == EXP_SPECIAL) begin
				nan_seen = 1'b1;
			end else begin
				total = element_sum + scaled_group_term(group_acc, act_scale, wgt_scale_half);
				if (total[127:SUM_W-1] == {(129-SUM_W){total[SUM_W-1]}}) begin
					element_sum = total[SUM_W-1:0];
				end else begin
					sat_seen    = 1'b1;
					element_sum = total[127] ? SUM_MIN : SUM_MAX;
				end
			end
			group_acc = '0;
		end
		if (output_end) begin
			owed_words.push_back('{element_sum, sat_seen, nan_seen});
			element_sum = '0;
			sat_seen    = 1'b0;
			nan_seen    = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
	endtask

	task automatic check_word();
		out_word_t e;
		if (owed_words.size() == 0) begin
			fail_count++;
			$display("%0t unexpected word: expected none actual sum_fixed %0d", $time, sum_fixed);
		end else begin
			e = owed_words.pop_front();
			if (sum_fixed !== e.sum)
				flag_mismatch("sum_fixed", e.sum, sum_fixed);
			if (overflow !== e.ovf)
				flag_mismatch("overflow", e.ovf, overflow);
			if (bad_scale !== e.bad)
				flag_mismatch("bad_scale", e.bad, bad_scale);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_acc    = '0;
			element_sum  = '0;
			sat_seen     = 1'b0;
			nan_seen     = 1'b0;
			results_owed = 0;
		end else begin
			if (pop && !empty)
				check_word();
			if (push && !full)
				absorb_word();
			results_owed = owed_words.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top for the group scaled int8 dot product block: stimulus and verdict
// depends on gsdp_pkg, group_scaled_int8_dot_product_top and gsdp_checker
module tb_top;
	import gsdp_pkg::*;

	// largest normal exponent of a half
	localparam logic [4:0] EXP_TOP = 5'd30;
	// receiver hold-off long enough to back the close queue up into full
	localparam int STALL_CYCLES = 300;
	localparam int IDLE_PCT     = 24;
	localparam int END_DRAIN    = 20;

	typedef enum int {DATA_RANDOM, DATA_EDGES, DATA_MAX_POS, DATA_MAX_NEG} data_mode_t;

	// one input word, lanes 0..3 in act[0..3] and wgt[0..3]
	typedef struct packed {
		logic [3:0][7:0] act;
		logic [3:0][7:0] wgt;
		logic [31:0]     ascale;
		logic [15:0]     half;
		logic            gend;
		logic            oend;
	} word_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [7:0]  act_a, act_b, act_c, act_d;
	logic signed [7:0]  wgt_a, wgt_b, wgt_c, wgt_d;
	logic [31:0]        act_scale;
	logic [15:0]        wgt_scale_half;
	logic               group_end;
	logic               output_end;
	logic               empty;
	logic               pop;
	logic signed [63:0] sum_fixed;
	logic               overflow;
	logic               bad_scale;
	int                 fail_count;
	int                 results_owed;

	// stimulus control shared by the sender and the receiver
	logic idle_on;
	logic stall_req;
	int   words_sent;

	group_scaled_int8_dot_product_top dut (.*);
	gsdp_checker chk (.*);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// byte picked mostly from the corners of the int8 range
	function automatic logic [7:0] edge_byte();
		case ($urandom_range(4))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// weight scale mix: mostly moderate normals, some specials, subnormals and extremes
	function automatic logic [15:0] pick_half();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return {1'($urandom), EXP_SPECIAL, 10'($urandom)};
		if (r < 12)
			return {1'($urandom), EXP_ZERO, 10'($urandom)};
		if (r < 18)
			return {1'($urandom), ($urandom_range(1) ? EXP_SUB : EXP_TOP), 10'($urandom)};
		if (r < 24)
			return 16'($urandom);
		return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
	endfunction

	// activation scale mostly below 4.0 so that sums rarely saturate
	function automatic logic [31:0] pick_ascale();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 32'h0400_0000);
		if (r < 88)
			return $urandom;
		return $urandom_range(1) ? '1 : '0;
	endfunction

	function automatic word_t make_word(data_mode_t mode);
		word_t w;
		for (int l = 0; l < 4; l++) begin
			case (mode)
				DATA_EDGES: begin
					w.act[l] = edge_byte();
					w.wgt[l] = edge_byte();
				end
				// -128 x -128 in every lane, the fastest climb of the group dot
				DATA_MAX_POS: begin
					w.act[l] = 8'h80;
					w.wgt[l] = 8'h80;
				end
				DATA_MAX_NEG: begin
					w.act[l] = 8'h80;
					w.wgt[l] = 8'h7F;
				end
				default: begin
					w.act[l] = 8'($urandom);
					w.wgt[l] = 8'($urandom);
				end
			endcase
		end
		w.ascale = pick_ascale();
		w.half   = pick_half();
		w.gend   = 1'b0;
		w.oend   = 1'b0;
		return w;
	endfunction

	// directed word with the same pair in all four lanes
	function automatic word_t flat_word(logic [7:0] a, logic [7:0] b, logic [31:0] s,
			logic [15:0] h, logic ge, logic oe);
		word_t w;
		w.act    = {4{a}};
		w.wgt    = {4{b}};
		w.ascale = s;
		w.half   = h;
		w.gend   = ge;
		w.oend   = oe;
		return w;
	endfunction

	// offer one word and hold it until the block takes it
	// entered and left at a falling edge; push stays high between back to back words
	task automatic send_word(input word_t w);
		if (idle_on)
			while ($urandom_range(99) < IDLE_PCT) begin
				push = 1'b0;
				@(negedge clk);
			end
		{act_d, act_c, act_b, act_a} = w.act;
		{wgt_d, wgt_c, wgt_b, wgt_a} = w.wgt;
		act_scale      = w.ascale;
		wgt_scale_half = w.half;
		group_end      = w.gend;
		output_end     = w.oend;
		push           = 1'b1;
		do
			@(posedge clk);
		while (full);
		words_sent++;
		@(negedge clk);
	endtask

	// one output element: a few groups, the last word carrying output_end
	// a broken element gets stray group ends and may close on output_end alone
	task automatic send_element(int groups, int lo_len, int hi_len, bit broken, data_mode_t mode);
		int    len;
		word_t w;
		for (int g = 0; g < groups; g++) begin
			len = $urandom_range(lo_len, hi_len);
			for (int i = 0; i < len; i++) begin
				w      = make_word(mode);
				w.gend = (i == len - 1);
				w.oend = (g == groups - 1) && (i == len - 1);
				if (broken) begin
					if ($urandom_range(9) == 0)
						w.gend = 1'b1;
					if (w.oend && $urandom_range(1))
						w.gend = 1'b0;
				end
				send_word(w);
			end
		end
	endtask

	task automatic random_step();
		int         r;
		data_mode_t mode;
		word_t      w;
		r    = $urandom_range(99);
		mode = ($urandom_range(99) < 70) ? DATA_RANDOM : DATA_EDGES;
		if (r < 78) begin
			send_element($urandom_range(1, 4), 1, 12, 1'b0, mode);
		end else if (r < 93) begin
			send_element($urandom_range(1, 3), 1, 8, 1'b1, mode);
		end else if (r < 96) begin
			// long group of max products, pushes the 22-bit group dot past its wrap
			send_element(1, 33, 70, 1'b0, $urandom_range(1) ? DATA_MAX_POS : DATA_MAX_NEG);
		end else begin
			// lone word with random markers
			w      = make_word(mode);
			w.gend = 1'($urandom);
			w.oend = 1'($urandom);
			send_word(w);
		end
	endtask

	// receiver: random pops, or a long counted hold-off when asked
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				pop = 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end
			pop = !idle_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		word_t w;
		arst_n         = 1'b0;
		push           = 1'b0;
		act_a          = '0;
		act_b          = '0;
		act_c          = '0;
		act_d          = '0;
		wgt_a          = '0;
		wgt_b          = '0;
		wgt_c          = '0;
		wgt_d          = '0;
		act_scale      = '0;
		wgt_scale_half = '0;
		group_end      = 1'b0;
		output_end     = 1'b0;
		idle_on        = 1'b1;
		stall_req      = 1'b0;
		words_sent     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words
		// plain element: 127 x 127 lanes, act scale 1.0, weight scale 1.0
		send_word(flat_word(8'h7F, 8'h7F, 32'h0100_0000, 16'h3C00, 1'b1, 1'b1));
		// saturate high, then low, in one group each
		send_word(flat_word(8'h80, 8'h80, 32'hFFFF_FFFF, 16'h7BFF, 1'b1, 1'b1));
		send_word(flat_word(8'h80, 8'h7F, 32'hFFFF_FFFF, 16'h7BFF, 1'b1, 1'b1));
		// saturate, then come back with a negative scale; the overflow flag must stick
		send_word(flat_word(8'h80, 8'h80, 32'hFFFF_FFFF, 16'h7BFF, 1'b1, 1'b0));
		send_word(flat_word(8'h80, 8'h80, 32'hFFFF_FFFF, 16'hFBFF, 1'b1, 1'b1));
		// tiny negative term, the floor shift must give -1 and not 0
		send_word(flat_word(8'h01, 8'hFF, 32'h0000_0001, 16'h0001, 1'b1, 1'b1));
		// subnormal max, negative subnormal min, zero and negative zero scales
		send_word(flat_word(8'h03, 8'h05, 32'h0080_0000, 16'h03FF, 1'b1, 1'b0));
		send_word(flat_word(8'hF9, 8'h09, 32'h1234_5678, 16'h8001, 1'b1, 1'b0));
		send_word(flat_word(8'h64, 8'h9C, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0));
		send_word(flat_word(8'h64, 8'h64, 32'h0100_0000, 16'h8000, 1'b1, 1'b1));
		// infinite scale adds nothing, the next group still counts, flag reported
		send_word(flat_word(8'h05, 8'h05, 32'h0100_0000, 16'h7C00, 1'b1, 1'b0));
		send_word(flat_word(8'h05, 8'h05, 32'h0100_0000, 16'h3C00, 1'b1, 1'b1));
		// NaN on the closing word itself
		send_word(flat_word(8'h05, 8'h05, 32'h0100_0000, 16'hFE01, 1'b1, 1'b1));
		// a group built over several words, closed by output_end alone
		send_word(flat_word(8'h00, 8'h00, 32'h0000_0000, 16'h0400, 1'b0, 1'b0));
		send_word(flat_word(8'h7F, 8'h80, 32'h0200_0000, 16'h4000, 1'b0, 1'b0));
		send_word(flat_word(8'h80, 8'h80, 32'h0000_0001, 16'h0400, 1'b0, 1'b1));
		// zero activation scale
		send_word(flat_word(8'h7F, 8'h7F, 32'h0000_0000, 16'h3C00, 1'b1, 1'b1));
		// all lanes different, negative weight scale
		w.act    = {8'hFF, 8'h00, 8'h80, 8'h7F};
		w.wgt    = {8'h01, 8'h80, 8'h7F, 8'hFF};
		w.ascale = 32'h0100_0000;
		w.half   = 16'hBC00;
		w.gend   = 1'b1;
		w.oend   = 1'b1;
		send_word(w);
		// all-ones NaN pattern
		send_word(flat_word(8'h80, 8'h80, 32'h0100_0000, 16'hFFFF, 1'b1, 1'b1));

		// sender pause: let every owed word drain
		push = 1'b0;
		wait (results_owed == 0);
		@(negedge clk);

		while (words_sent < 600)
			random_step();

		// receiver holds off while short elements keep coming, so full must rise
		stall_req = 1'b1;
		repeat (40) send_element(1, 1, 2, 1'b0, DATA_RANDOM);
		push = 1'b0;
		wait (results_owed == 0);
		@(negedge clk);

		// a stretch with no idling on either side
		idle_on = 1'b0;
		while (words_sent < 950)
			random_step();
		idle_on = 1'b1;
		while (words_sent < 1650)
			random_step();

		// drain, then keep watching to catch any stray word
		push = 1'b0;
		wait (results_owed == 0);
		repeat (END_DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/gsdp_pkg.sv
rtl/gsdp_front.sv
rtl/gsdp_queue.sv
rtl/gsdp_back.sv
rtl/group_scaled_int8_dot_product_top.sv
rtl/gsdp_checker.sv
tb/gsdp_checker.sv
tb/tb_top.sv
